/* hdl/qrs_pkg.sv */
// Shared constants, case codes and item types for the quadratic root solver.
package qrs_pkg;

  localparam int COEFF_WIDTH   = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_WIDTH     = 40;

  localparam logic [1:0] CASE_NONE    = 2'd0;
  localparam logic [1:0] CASE_TWO     = 2'd1;
  localparam logic [1:0] CASE_DOUBLE  = 2'd2;
  localparam logic [1:0] CASE_COMPLEX = 2'd3;

  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] coef_a;
    logic signed [COEFF_WIDTH-1:0] coef_b;
    logic signed [COEFF_WIDTH-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic [1:0]                  root_case;
    logic signed [OUT_WIDTH-1:0] first_value;
    logic signed [OUT_WIDTH-1:0] second_value;
  } root_t;

endpackage

/* hdl/quadratic_root_solver_top.sv */
// Quadratic root solver: discriminant, square-root cell chain, divider cell chains.
// Registers from accept to result valid: stage 1, stage 2, SW sqrt cells, stage 3, NW divider cells, output;
//   SW = root bits (one sqrt cell each), NW = quotient bits (one divider cell each).
// Throughput: one item per cycle; the whole pipe advances unless the output
//   register holds an item that is not taken.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module quadratic_root_solver_top #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  qrs_pkg::coef_t coef,
  input  logic          coef_valid,
  output logic          coef_ready,
  output qrs_pkg::root_t root,
  output logic          root_valid,
  input  logic          root_ready
);
  import qrs_pkg::*;

  localparam int CW  = COEFF_WIDTH;
  localparam int DW  = 2 * CW + 1;
  localparam int RW  = DW + 2 * FRAC_BITS;
  localparam int SW  = (RW + 1) / 2;
  localparam int RAD = 2 * SW;
  localparam int MW  = (CW + FRAC_BITS > SW) ? CW + FRAC_BITS : SW;
  localparam int NW  = MW + 1;
  localparam int SXW = NW + 2;
  localparam int DVW = CW + 1;
  localparam int QX  = (NW > OUT_WIDTH) ? NW + 1 : OUT_WIDTH + 1;

  logic en;
  assign en         = !root_valid || root_ready;
  assign coef_ready = en;

  // stage 1: products
  logic [CW-1:0]   mag_a, mag_b, mag_c;
  logic [2*CW-1:0] bsq, pac;
  logic            s1_vld;
  logic signed [CW-1:0] s1_a, s1_b;
  logic [2*CW-1:0] s1_bsq, s1_pac;
  logic            s1_acneg;

  assign mag_a = coef.coef_a[CW-1] ? CW'(-coef.coef_a) : coef.coef_a;
  assign mag_b = coef.coef_b[CW-1] ? CW'(-coef.coef_b) : coef.coef_b;
  assign mag_c = coef.coef_c[CW-1] ? CW'(-coef.coef_c) : coef.coef_c;
  assign bsq   = mag_b * mag_b;
  assign pac   = mag_a * mag_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a     <= coef.coef_a;
      s1_b     <= coef.coef_b;
      s1_bsq   <= bsq;
      s1_pac   <= pac;
      s1_acneg <= (coef.coef_a[CW-1] ^ coef.coef_c[CW-1]) && (coef.coef_a != '0)
                  && (coef.coef_c != '0);
    end
  end

  // stage 2: discriminant sign and magnitude
  logic [2*CW+2:0] dsum, ddif;
  logic [2*CW+2:0] dmag_w;
  logic            dneg;
  logic [DW-1:0]   dmag;
  logic [1:0]      kase;

  assign dsum   = {3'b000, s1_bsq} + {1'b0, s1_pac, 2'b00};
  assign ddif   = {3'b000, s1_bsq} - {1'b0, s1_pac, 2'b00};
  assign dneg   = !s1_acneg && ddif[2*CW+2];
  assign dmag_w = s1_acneg ? dsum : (dneg ? -ddif : ddif);
  assign dmag   = dmag_w[DW-1:0];

  always_comb begin
    if (s1_a == '0) begin
      kase = CASE_NONE;
    end else if (dneg) begin
      kase = CASE_COMPLEX;
    end else if (dmag == '0) begin
      kase = CASE_DOUBLE;
    end else begin
      kase = CASE_TWO;
    end
  end

  // square-root chain; index 0 of the side arrays is the stage-2 register
  logic [SW:0]          sq_vld;
  logic [1:0]           sq_kase [0:SW];
  logic signed [CW-1:0] sq_a    [0:SW];
  logic signed [CW-1:0] sq_b    [0:SW];
  logic [DW-1:0]        s2_mag;
  logic [SW+1:0]        sq_rem  [0:SW];
  logic [SW-1:0]        sq_root [0:SW];
  logic [RAD-1:0]       sq_rad  [0:SW];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag     <= dmag;
      sq_kase[0] <= kase;
      sq_a[0]    <= s1_a;
      sq_b[0]    <= s1_b;
      for (int i = 0; i < SW; i++) begin
        sq_kase[i+1] <= sq_kase[i];
        sq_a[i+1]    <= sq_a[i];
        sq_b[i+1]    <= sq_b[i];
      end
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {{(RAD-DW){1'b0}}, s2_mag} << (2 * FRAC_BITS);

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .rad_in   (sq_rad[g]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .rad_out  (sq_rad[g+1])
    );
  end

  // stage 3: numerators, signs and divisor
  logic signed [SXW-1:0] nbx, sx, n1, n2;
  logic [SXW-1:0]        m1, m2;
  logic                  is_two;
  logic [CW-1:0]         mag_fa;

  assign is_two = (sq_kase[SW] == CASE_TWO);
  assign nbx    = -(SXW'(sq_b[SW]) <<< FRAC_BITS);
  assign sx     = $signed({{(SXW-SW){1'b0}}, sq_root[SW]});
  assign n1     = is_two ? nbx + sx : nbx;
  assign n2     = is_two ? nbx - sx : sx;
  assign m1     = n1[SXW-1] ? -n1 : n1;
  assign m2     = n2[SXW-1] ? -n2 : n2;
  assign mag_fa = sq_a[SW][CW-1] ? CW'(-sq_a[SW]) : sq_a[SW];

  logic [NW:0]    dv_vld;
  logic [1:0]     dv_kase [0:NW];
  logic           dv_sg1  [0:NW];
  logic           dv_sg2  [0:NW];
  logic [DVW-1:0] dv_rem1 [0:NW];
  logic [DVW-1:0] dv_rem2 [0:NW];
  logic [NW-1:0]  dv_num1 [0:NW];
  logic [NW-1:0]  dv_num2 [0:NW];
  logic [DVW-1:0] dv_den1 [0:NW];
  logic [DVW-1:0] dv_den2 [0:NW];
  logic [NW-1:0]  s3_m1, s3_m2;
  logic [DVW-1:0] s3_den;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_m1      <= m1[NW-1:0];
      s3_m2      <= m2[NW-1:0];
      s3_den     <= {mag_fa, 1'b0};
      dv_kase[0] <= sq_kase[SW];
      dv_sg1[0]  <= n1[SXW-1] ^ sq_a[SW][CW-1];
      dv_sg2[0]  <= is_two ? (n2[SXW-1] ^ sq_a[SW][CW-1]) : 1'b0;
      for (int i = 0; i < NW; i++) begin
        dv_kase[i+1] <= dv_kase[i];
        dv_sg1[i+1]  <= dv_sg1[i];
        dv_sg2[i+1]  <= dv_sg2[i];
      end
    end
  end

  assign dv_rem1[0] = '0;
  assign dv_rem2[0] = '0;
  assign dv_num1[0] = s3_m1;
  assign dv_num2[0] = s3_m2;
  assign dv_den1[0] = s3_den;
  assign dv_den2[0] = s3_den;

  for (genvar g = 0; g < NW; g++) begin : g_div
    qrs_div_cell #(.NW(NW), .DVW(DVW)) u_first (
      .clk     (clk),
      .en      (en),
      .rem_in  (dv_rem1[g]),
      .num_in  (dv_num1[g]),
      .den_in  (dv_den1[g]),
      .rem_out (dv_rem1[g+1]),
      .num_out (dv_num1[g+1]),
      .den_out (dv_den1[g+1])
    );
    qrs_div_cell #(.NW(NW), .DVW(DVW)) u_second (
      .clk     (clk),
      .en      (en),
      .rem_in  (dv_rem2[g]),
      .num_in  (dv_num2[g]),
      .den_in  (dv_den2[g]),
      .rem_out (dv_rem2[g+1]),
      .num_out (dv_num2[g+1]),
      .den_out (dv_den2[g+1])
    );
  end

  // sign and clamp to the output range
  function automatic logic signed [OUT_WIDTH-1:0] sat(input logic [NW-1:0] q,
                                                     input logic neg);
    logic [QX-1:0] qx;
    logic [QX-1:0] lim;
    qx  = QX'(q);
    lim = QX'(1) << (OUT_WIDTH - 1);
    if (neg) begin
      sat = (qx > lim) ? -OUT_WIDTH'(lim) : -qx[OUT_WIDTH-1:0];
    end else begin
      sat = (qx > lim - QX'(1)) ? OUT_WIDTH'(lim - QX'(1)) : qx[OUT_WIDTH-1:0];
    end
  endfunction

  logic signed [OUT_WIDTH-1:0] v1, v2;
  root_t                       res;

  assign v1 = sat(dv_num1[NW], dv_sg1[NW]);
  assign v2 = sat(dv_num2[NW], dv_sg2[NW]);

  always_comb begin
    res.root_case = dv_kase[NW];
    case (dv_kase[NW])
      CASE_NONE: begin
        res.first_value  = '0;
        res.second_value = '0;
      end
      CASE_DOUBLE: begin
        res.first_value  = v1;
        res.second_value = v1;
      end
      default: begin
        res.first_value  = v1;
        res.second_value = v2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld     <= 1'b0;
      sq_vld     <= '0;
      dv_vld     <= '0;
      root_valid <= 1'b0;
    end else if (en) begin
      s1_vld     <= coef_valid;
      sq_vld     <= {sq_vld[SW-1:0], s1_vld};
      dv_vld     <= {dv_vld[NW-1:0], sq_vld[SW]};
      root_valid <= dv_vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= res;
    end
  end

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_case == CASE_NONE |->
      root.first_value == '0 && root.second_value == '0)
    else $error("non-quadratic item carries nonzero values");

  a_double_same: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_case == CASE_DOUBLE |-> root.first_value == root.second_value)
    else $error("double root with differing values");

  a_imag_pos: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_case == CASE_COMPLEX |-> !root.second_value[OUT_WIDTH-1])
    else $error("negative imaginary part");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_vld) && $stable(sq_vld))
    else $error("pipeline moved while output stalled");

endmodule

/* hdl/qrs_sqrt_cell.sv */
// One restoring square-root cell: retires one root bit per cycle while en is high.
module qrs_sqrt_cell #(
  parameter int SW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SW+1:0]   rem_in,
  input  logic [SW-1:0]   root_in,
  input  logic [2*SW-1:0] rad_in,
  output logic [SW+1:0]   rem_out,
  output logic [SW-1:0]   root_out,
  output logic [2*SW-1:0] rad_out
);

  logic [SW+3:0] rem_sh;
  logic [SW+3:0] trial;
  logic [SW+3:0] diff;
  logic          ge;

  assign rem_sh = {rem_in, rad_in[2*SW-1 -: 2]};
  assign trial  = {2'b00, root_in, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[SW+1:0] : rem_sh[SW+1:0];
      root_out <= {root_in[SW-2:0], ge};
      rad_out  <= {rad_in[2*SW-3:0], 2'b00};
    end
  end

endmodule

/* hdl/qrs_div_cell.sv */
// One restoring divider cell: retires one quotient bit per cycle while en is high.
module qrs_div_cell #(
  parameter int NW  = 34,
  parameter int DVW = 17
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] rem_in,
  input  logic [NW-1:0]  num_in,
  input  logic [DVW-1:0] den_in,
  output logic [DVW-1:0] rem_out,
  output logic [NW-1:0]  num_out,
  output logic [DVW-1:0] den_out
);

  logic [DVW:0] trial;
  logic [DVW:0] diff;
  logic         ge;

  assign trial = {rem_in, num_in[NW-1]};
  assign diff  = trial - {1'b0, den_in};
  assign ge    = (trial >= {1'b0, den_in});

  // quotient bits shift in at the bottom as numerator bits leave the top
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      num_out <= {num_in[NW-2:0], ge};
      den_out <= den_in;
    end
  end

endmodule

/* sim/quadratic_root_solver_top_test.sv */
// Self-checking testbench for the quadratic root solver: random and directed coefficient sets.
module quadratic_root_solver_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  coef_t  coef = '0;
  logic   coef_valid = 1'b0;
  logic   coef_ready;
  root_t  root;
  logic   root_valid;
  logic   root_ready = 1'b0;

  coef_t  coef_pending[$];
  root_t  roots_expected[$];
  int     errors = 0;
  int     cycles = 0;
  int     results_seen = 0;
  bit     coef_taken = 1'b0;
  bit     long_hold_done = 1'b0;
  int     send_gap = 0;
  int     recv_gap = 0;

  quadratic_root_solver_top dut (
    .clk(clk), .rst(rst), .coef(coef), .coef_valid(coef_valid), .coef_ready(coef_ready),
    .root(root), .root_valid(root_valid), .root_ready(root_ready)
  );

  always #5 clk = ~clk;

  function automatic logic signed [OUT_WIDTH-1:0] clamp_out(longint v);
    longint hi;
    hi = (64'sd1 <<< (OUT_WIDTH - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[OUT_WIDTH-1:0];
  endfunction

  // exact discriminant, floored fixed-point sqrt, truncating quotients
  function automatic root_t solve_roots(coef_t k);
    longint a, b, c, disc, nb, den, s;
    logic [127:0] mag, trial, acc;
    root_t r;
    a = k.coef_a;
    b = k.coef_b;
    c = k.coef_c;
    r = '0;
    if (a == 0) begin
      r.root_case = CASE_NONE;
      return r;
    end
    disc = b * b - 4 * a * c;
    mag = disc < 0 ? -disc : disc;
    mag = mag << (2 * FRAC);
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = acc | (128'd1 << i);
      if (trial * trial <= mag) acc = trial;
    end
    s = acc[63:0];
    nb = -b * (64'sd1 <<< FRAC);
    den = 2 * a;
    if (disc > 0) begin
      r.root_case = CASE_TWO;
      r.first_value = clamp_out((nb + s) / den);
      r.second_value = clamp_out((nb - s) / den);
    end else if (disc == 0) begin
      r.root_case = CASE_DOUBLE;
      r.first_value = clamp_out(nb / den);
      r.second_value = r.first_value;
    end else begin
      r.root_case = CASE_COMPLEX;
      r.first_value = clamp_out(nb / den);
      r.second_value = clamp_out(s / (den < 0 ? -den : den));
    end
    return r;
  endfunction

  function automatic coef_t make_coef(int a, int b, int c);
    coef_t k;
    k.coef_a = a[15:0];
    k.coef_b = b[15:0];
    k.coef_c = c[15:0];
    return k;
  endfunction

  // accept side: record items taken and check results
  always @(posedge clk) begin
    root_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("FAILED: results differ");
      $finish;
    end
    coef_taken = 1'b0;
    if (!rst && coef_valid && coef_ready) begin
      roots_expected.push_back(solve_roots(coef));
      coef_taken = 1'b1;
    end
    if (!rst && root_valid && root_ready) begin
      results_seen <= results_seen + 1;
      if (roots_expected.size() == 0) begin
        $display("%0t unexpected item: actual %p", $time, root);
        errors <= errors + 1;
      end else begin
        want = roots_expected.pop_front();
        if (root.root_case !== want.root_case || root.first_value !== want.first_value ||
            root.second_value !== want.second_value) begin
          $display("%0t mismatch: expected case %0d %0d %0d, actual case %0d %0d %0d",
                   $time, want.root_case, want.first_value, want.second_value,
                   root.root_case, root.first_value, root.second_value);
          errors <= errors + 1;
        end
      end
    end
  end

  // sender: next item at the falling edge, with random bursts of idling
  always @(negedge clk) begin
    if (!rst && (!coef_valid || coef_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        coef_valid <= 1'b0;
      end else if (coef_valid && coef_pending.size() > 150 && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 17);
        coef_valid <= 1'b0;
      end else if (coef_pending.size() > 0) begin
        coef <= coef_pending.pop_front();
        coef_valid <= 1'b1;
      end else begin
        coef_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, and one long hold-off so the pipe fills and backs up
  always @(negedge clk) begin
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        root_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 150) begin
        long_hold_done <= 1'b1;
        recv_gap <= 300;
        root_ready <= 1'b0;
      end else if (coef_pending.size() > 150 && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 17);
        root_ready <= 1'b0;
      end else begin
        root_ready <= 1'b1;
      end
    end
  end

  initial begin
    int a, b, c, m;
    // zero a, extremes, each root case
    coef_pending.push_back(make_coef(0, 0, 0));
    coef_pending.push_back(make_coef(0, 32767, -32768));
    coef_pending.push_back(make_coef(1, -3, 2));
    coef_pending.push_back(make_coef(1, 2, 1));
    coef_pending.push_back(make_coef(1, 256, 16384));
    coef_pending.push_back(make_coef(-4, 4, -1));
    coef_pending.push_back(make_coef(1, 0, 1));
    coef_pending.push_back(make_coef(-1, 1, -5));
    coef_pending.push_back(make_coef(32767, 32767, 32767));
    coef_pending.push_back(make_coef(-32768, -32768, -32768));
    coef_pending.push_back(make_coef(-32768, 32767, 32767));
    coef_pending.push_back(make_coef(32767, -32768, -32768));
    coef_pending.push_back(make_coef(-32768, 0, 32767));
    coef_pending.push_back(make_coef(32767, 0, 32767));
    coef_pending.push_back(make_coef(1, -32768, 0));
    coef_pending.push_back(make_coef(-1, 32767, 0));
    coef_pending.push_back(make_coef(-1, -1, -1));
    coef_pending.push_back(make_coef(3, 0, 0));
    coef_pending.push_back(make_coef(-32768, -32768, 0));
    for (int n = 0; n < 600; n++) begin
      case ($urandom_range(0, 3))
        0: begin
          a = $urandom_range(0, 65535) - 32768;
          b = $urandom_range(0, 65535) - 32768;
          c = $urandom_range(0, 65535) - 32768;
        end
        1: begin
          a = $urandom_range(0, 40) - 20;
          b = $urandom_range(0, 40) - 20;
          c = $urandom_range(0, 40) - 20;
        end
        2: begin
          // perfect square: a*(x+m)^2
          a = $urandom_range(0, 60) - 30;
          m = $urandom_range(0, 60) - 30;
          b = 2 * a * m;
          c = a * m * m;
        end
        default: begin
          a = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 300);
          b = $urandom_range(0, 65535) - 32768;
          c = $urandom_range(0, 2000) - 1000;
        end
      endcase
      coef_pending.push_back(make_coef(a, b, c));
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (coef_pending.size() == 0 && !coef_valid);
    wait (roots_expected.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver_top.sv
sim/quadratic_root_solver_top_test.sv
